/* rtl/core/ibcc_pkg.sv */
package ibcc_pkg;

    // Default sizing for the top-level parameters
    localparam int MAX_SIDE_DEF    = 1024;
    localparam int MAX_BIN_DEF     = 16;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed field widths
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 40;
    localparam int CROP_W     = 10;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SIDE_REG_W = 11;
    localparam int BIN_REG_W  = 5;
    localparam int CROP_REG_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROP_SIDE  = 2'd2;

    // Reset values of the registers
    localparam logic [SIDE_REG_W-1:0] IMAGE_SIDE_RST = 11'd512;
    localparam logic [BIN_REG_W-1:0]  BIN_FACTOR_RST = 5'd2;
    localparam logic [CROP_REG_W-1:0] CROP_SIDE_RST  = 11'd256;

endpackage

/* rtl/core/image_bin_and_center_crop.sv */
// Sums each bin_factor x bin_factor block of a square raster image into one
// binned pixel and emits only the centered crop_side window of the binned
// image, flagging its bottom-right pixel. The block takes one sample word per clock
// while the output is not stalled by a low m_ready, and returns a binned word through
// the stage-1 and output registers; the pace is set by the line store of partial column
// sums (MAX_SIDE x 40 bits), read when a sample is taken and written back when that
// sample leaves stage 1, with a bypass for a write and read of the same column. The
// line store has no clear: the first row of each block row overwrites the stale sums.
// Configuration takes effect for the sample after the write.
module image_bin_and_center_crop
    import ibcc_pkg::*;
#(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int MAX_BIN     = MAX_BIN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SUM_W-1:0]      m_binned_value,
    output logic [CROP_W-1:0]     m_crop_row,
    output logic [CROP_W-1:0]     m_crop_col,
    output logic                  m_frame_last
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int BIN_W  = $clog2(MAX_BIN + 1);
    localparam int CNT_W  = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;

    // geometry
    logic [SIDE_W-1:0] side, bside, low, win_end, last_idx;
    logic [BIN_W-1:0]  bin;

    ibcc_cfg #(
        .MAX_SIDE (MAX_SIDE),
        .MAX_BIN  (MAX_BIN),
        .SIDE_W   (SIDE_W),
        .BIN_W    (BIN_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .side      (side),
        .bin       (bin),
        .bside     (bside),
        .low       (low),
        .win_end   (win_end),
        .last_idx  (last_idx)
    );

    // raster position state
    logic [POS_W-1:0] row_pos_reg, row_pos_next, col_pos_reg, col_pos_next;
    logic [CNT_W-1:0] rib_reg, rib_next, cib_reg, cib_next;
    logic [SUM_W-1:0] hsum_reg, hsum_next;

    // stage 1
    logic              s1_valid_reg, s1_write_reg, s1_emit_reg, s1_first_reg, s1_last_reg;
    logic [SUM_W-1:0]  s1_hsum_reg;
    logic [POS_W-1:0]  s1_bc_reg;
    logic [CROP_W-1:0] s1_row_reg, s1_col_reg;
    logic              fwd_reg;
    logic [SUM_W-1:0]  fwd_data_reg;

    // output register
    logic              m_valid_reg;
    logic [SUM_W-1:0]  m_value_reg;
    logic [CROP_W-1:0] m_row_reg, m_col_reg;
    logic              m_last_reg;

    // stage 0 combinational
    logic              accept;
    logic [POS_W-1:0]  rp, cp, br, bc;
    logic [CNT_W-1:0]  rib, cib;
    logic [SUM_W-1:0]  hs, hs_add;
    logic [SIDE_W-1:0] br_w, bc_w, cp1, rp1;
    logic              in_used, col_done, row_done, in_win, row_used;
    logic              emit0, last0, write0;
    logic [CROP_W-1:0] r0, c0;

    // stage 1 combinational
    logic              s1_go, out_free, wr_en;
    logic [SUM_W-1:0]  rd_data, prev, tot;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign accept   = s_valid && s_ready;

    // frame start restarts the raster position
    always_comb begin
        rp  = s_frame_start ? '0 : row_pos_reg;
        cp  = s_frame_start ? '0 : col_pos_reg;
        rib = s_frame_start ? '0 : rib_reg;
        cib = s_frame_start ? '0 : cib_reg;
        hs  = s_frame_start ? '0 : hsum_reg;
    end

    // block coordinates of the current sample
    ibcc_div #(
        .VAL_W   (POS_W),
        .BIN_W   (BIN_W),
        .MAX_BIN (MAX_BIN)
    ) u_row_div (
        .value   (rp),
        .divisor (bin),
        .quot    (br)
    );

    ibcc_div #(
        .VAL_W   (POS_W),
        .BIN_W   (BIN_W),
        .MAX_BIN (MAX_BIN)
    ) u_col_div (
        .value   (cp),
        .divisor (bin),
        .quot    (bc)
    );

    // block tests and window check
    always_comb begin
        br_w     = SIDE_W'(br);
        bc_w     = SIDE_W'(bc);
        row_used = br_w < bside;
        in_used  = row_used && (bc_w < bside);
        col_done = (BIN_W'(cib) + BIN_W'(1)) >= bin;
        row_done = (BIN_W'(rib) + BIN_W'(1)) >= bin;
        in_win   = (br_w >= low) && (br_w < win_end) && (bc_w >= low) && (bc_w < win_end);
        hs_add   = hs + SUM_W'(s_sample[SAMPLE_BITS-1:0]);
        write0   = in_used && col_done;
        emit0    = write0 && row_done && in_win;
        last0    = (br_w == last_idx) && (bc_w == last_idx);
        r0       = CROP_W'(br_w - low);
        c0       = CROP_W'(bc_w - low);
    end

    // next raster position
    always_comb begin
        hsum_next = hs;
        cib_next  = cib;
        rib_next  = rib;
        row_pos_next = rp;
        if (in_used) begin
            if (col_done) begin
                hsum_next = '0;
                cib_next  = '0;
            end else begin
                hsum_next = hs_add;
                cib_next  = CNT_W'(cib + CNT_W'(1));
            end
        end
        cp1 = SIDE_W'(cp) + SIDE_W'(1);
        rp1 = SIDE_W'(rp) + SIDE_W'(1);
        if (cp1 >= side) begin
            col_pos_next = '0;
            cib_next     = '0;
            hsum_next    = '0;
            if (row_used) begin
                rib_next = row_done ? '0 : CNT_W'(rib + CNT_W'(1));
            end
            if (rp1 >= side) begin
                row_pos_next = '0;
                rib_next     = '0;
            end else begin
                row_pos_next = POS_W'(rp1);
            end
        end else begin
            col_pos_next = POS_W'(cp1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            rib_reg     <= '0;
            cib_reg     <= '0;
            hsum_reg    <= '0;
        end else if (accept) begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            rib_reg     <= rib_next;
            cib_reg     <= cib_next;
            hsum_reg    <= hsum_next;
        end
    end

    // line store of partial column sums
    assign wr_en = s1_go && s1_write_reg;

    ibcc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SIDE)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_bc_reg),
        .wr_data (tot),
        .rd_en   (accept),
        .rd_addr (bc),
        .rd_data (rd_data)
    );

    // stage 1: add the partial sum carried from the rows above
    always_comb begin
        prev = fwd_reg ? fwd_data_reg : rd_data;
        tot  = (s1_first_reg ? '0 : prev) + s1_hsum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_write_reg <= write0;
            s1_emit_reg  <= emit0;
            s1_first_reg <= (rib == '0);
            s1_last_reg  <= last0;
            s1_hsum_reg  <= hs_add;
            s1_bc_reg    <= bc;
            s1_row_reg   <= r0;
            s1_col_reg   <= c0;
            // bypass a write-back to the column being read
            fwd_reg      <= wr_en && (s1_bc_reg == bc);
            fwd_data_reg <= tot;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_go && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go && s1_emit_reg) begin
            m_value_reg <= tot;
            m_row_reg   <= s1_row_reg;
            m_col_reg   <= s1_col_reg;
            m_last_reg  <= s1_last_reg && (s1_row_reg == s1_col_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_binned_value = m_value_reg;
    assign m_crop_row     = m_row_reg;
    assign m_crop_col     = m_col_reg;
    assign m_frame_last   = m_last_reg;

endmodule

/* rtl/core/ibcc_div.sv */
// Quotient of a narrow value by a small divisor (1 .. MAX_BIN): one constant
// reciprocal multiplication per possible divisor, then a select.
module ibcc_div
    import ibcc_pkg::*;
#(
    parameter int VAL_W   = 10,
    parameter int BIN_W   = 5,
    parameter int MAX_BIN = MAX_BIN_DEF
) (
    input  logic [VAL_W-1:0] value,
    input  logic [BIN_W-1:0] divisor,
    output logic [VAL_W-1:0] quot
);

    // a shift of VAL_W + BIN_W bits keeps the rounded-up reciprocal exact
    // for every VAL_W-bit value and every divisor below 2**BIN_W
    localparam int SHIFT  = VAL_W + BIN_W;
    localparam int PROD_W = VAL_W + SHIFT + 1;

    logic [VAL_W-1:0] q_arr [MAX_BIN];

    // constant dividers: multiply by the reciprocal, keep the high bits
    for (genvar k = 1; k <= MAX_BIN; k++) begin : g_div
        localparam longint Recip = (longint'(1) << SHIFT) / longint'(k) + longint'(1);
        logic [PROD_W-1:0] prod;
        assign prod        = PROD_W'(value) * PROD_W'(Recip);
        assign q_arr[k-1]  = VAL_W'(prod >> SHIFT);
    end

    // pick the one matching the divisor
    always_comb begin
        quot = value;
        for (int k = 1; k <= MAX_BIN; k++) begin
            if (divisor == BIN_W'(k)) begin
                quot = q_arr[k-1];
            end
        end
    end

endmodule

/* rtl/core/ibcc_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
module ibcc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/ibcc_cfg.sv */
// Configuration registers plus the derived geometry: effective side and bin,
// binned side, clamped crop and window bounds. The derived values are
// recomputed from the next register values so they are ready the cycle
// after a write.
module ibcc_cfg
    import ibcc_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF,
    parameter int MAX_BIN  = MAX_BIN_DEF,
    parameter int SIDE_W   = $clog2(MAX_SIDE + 1),
    parameter int BIN_W    = $clog2(MAX_BIN + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [SIDE_W-1:0]     side,
    output logic [BIN_W-1:0]      bin,
    output logic [SIDE_W-1:0]     bside,
    output logic [SIDE_W-1:0]     low,
    output logic [SIDE_W-1:0]     win_end,
    output logic [SIDE_W-1:0]     last_idx
);

    logic [SIDE_REG_W-1:0] side_reg, side_next;
    logic [BIN_REG_W-1:0]  bin_reg, bin_next;
    logic [CROP_REG_W-1:0] crop_reg, crop_next;

    logic [SIDE_W-1:0] eside_next, bside_next, ecrop_next, low_next, win_end_next;
    logic [BIN_W-1:0]  ebin_next;
    logic [31:0]       crop1;

    logic [SIDE_W-1:0] side_reg_d, bside_reg, low_reg, win_end_reg, last_reg;
    logic [BIN_W-1:0]  bin_reg_d;

    // register writes; reset values are forced while in reset
    always_comb begin
        side_next = side_reg;
        bin_next  = bin_reg;
        crop_next = crop_reg;
        if (!aresetn) begin
            side_next = IMAGE_SIDE_RST;
            bin_next  = BIN_FACTOR_RST;
            crop_next = CROP_SIDE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_SIDE: side_next = cfg_wdata[SIDE_REG_W-1:0];
                REG_BIN_FACTOR: bin_next  = cfg_wdata[BIN_REG_W-1:0];
                REG_CROP_SIDE:  crop_next = cfg_wdata[CROP_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        side_reg <= side_next;
        bin_reg  <= bin_next;
        crop_reg <= crop_next;
    end

    // clamp side and bin into their supported ranges
    always_comb begin
        if (side_next == '0) begin
            eside_next = SIDE_W'(1);
        end else if (32'(side_next) > 32'(MAX_SIDE)) begin
            eside_next = SIDE_W'(MAX_SIDE);
        end else begin
            eside_next = SIDE_W'(side_next);
        end
        if (bin_next == '0) begin
            ebin_next = BIN_W'(1);
        end else if (32'(bin_next) > 32'(MAX_BIN)) begin
            ebin_next = BIN_W'(MAX_BIN);
        end else begin
            ebin_next = BIN_W'(bin_next);
        end
    end

    ibcc_div #(
        .VAL_W   (SIDE_W),
        .BIN_W   (BIN_W),
        .MAX_BIN (MAX_BIN)
    ) u_bside_div (
        .value   (eside_next),
        .divisor (ebin_next),
        .quot    (bside_next)
    );

    // crop clamped to [1, bside], window centered
    always_comb begin
        crop1 = (crop_next == '0) ? 32'd1 : 32'(crop_next);
        if (crop1 > 32'(bside_next)) begin
            ecrop_next = bside_next;
        end else begin
            ecrop_next = SIDE_W'(crop1);
        end
        low_next     = (bside_next - ecrop_next) >> 1;
        win_end_next = low_next + ecrop_next;
    end

    always_ff @(posedge aclk) begin
        side_reg_d  <= eside_next;
        bin_reg_d   <= ebin_next;
        bside_reg   <= bside_next;
        low_reg     <= low_next;
        win_end_reg <= win_end_next;
        last_reg    <= win_end_next - SIDE_W'(1);
    end

    assign side     = side_reg_d;
    assign bin      = bin_reg_d;
    assign bside    = bside_reg;
    assign low      = low_reg;
    assign win_end  = win_end_reg;
    assign last_idx = last_reg;

endmodule
